@@ rtl/lir_pkg.sv @@
// ----------------------------------------------------------------------------
// lir_pkg: shared definitions for the linear interpolation resampler
// Sample and phase widths, phase constants, register indexes and the command
// and status groups that join the controller to the datapath.
// ----------------------------------------------------------------------------
package lir_pkg;

	// Sample and phase geometry.
	localparam int SAMPLE_BITS     = 24;
	localparam int PHASE_FRAC_BITS = 20;
	localparam int PHASE_BITS      = PHASE_FRAC_BITS + 5;
	localparam int MAX_UPSAMPLE    = 16;
	localparam int MAX_CHANNELS    = 2;
	localparam int CNT_BITS        = $clog2(MAX_UPSAMPLE);

	// Product of a difference (SAMPLE_BITS+1) and a phase of at most 1.0.
	localparam int PROD_BITS = SAMPLE_BITS + PHASE_FRAC_BITS + 3;

	// Phase constants in unsigned Q5.PHASE_FRAC_BITS.
	localparam logic [PHASE_BITS-1:0] PH_ONE   = PHASE_BITS'(64'd1 << PHASE_FRAC_BITS);
	localparam logic [PHASE_BITS-1:0] STEP_MIN = PHASE_BITS'(
		((64'd1 << PHASE_FRAC_BITS) + 64'(MAX_UPSAMPLE) - 64'd1) / 64'(MAX_UPSAMPLE));
	localparam logic [PHASE_BITS-1:0] STEP_MAX = PHASE_BITS'(64'd16 << PHASE_FRAC_BITS);
	localparam logic [PROD_BITS-1:0]  ROUND_BIAS = PROD_BITS'((64'd1 << PHASE_FRAC_BITS) - 64'd1);

	// Configuration port.
	localparam int CFG_IDX_BITS  = 2;
	localparam int CFG_DATA_BITS = PHASE_BITS;
	localparam logic [CFG_IDX_BITS-1:0] REG_RESAMPLE_ENABLE = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_STEP_RATIO      = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_STEREO_MODE     = 2'd2;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;
	typedef logic [PHASE_BITS-1:0]         phase_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;   // capture the incoming frame
		logic mul;      // form the interpolation products
		logic emit;     // load one interpolated result into the output register
		logic pass;     // load the frame unchanged into the output register
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic bypass;   // interpolation is switched off
		logic skip;     // the next frame gives no result, the phase is past 1.0
		logic stop;     // the result being emitted is the last of this frame
	} status_t;

endpackage

@@ rtl/lir_ctrl.sv @@
// ----------------------------------------------------------------------------
// lir_ctrl: sequencing for the linear interpolation resampler
// Accepts one frame at a time, steps the datapath through multiply and emit
// phases per result, or a pass if bypassed, and owns the output valid flag.
// ----------------------------------------------------------------------------
module lir_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	input  lir_pkg::status_t status,
	output lir_pkg::cmd_t    cmd
);
	import lir_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_EMIT,
		ST_PASS
	} state_t;

	state_t state_q;
	state_t state_nx;
	logic   out_valid_q;
	logic   slot_free;

	// The output register can take a new beat when empty or being emptied.
	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	// Commands decoded from the current state.
	always_comb begin
		cmd.accept = in_valid && (state_q == ST_IDLE);
		cmd.mul    = (state_q == ST_MUL);
		cmd.emit   = (state_q == ST_EMIT) && slot_free;
		cmd.pass   = (state_q == ST_PASS) && slot_free;
	end

	// Next state. A frame that gives no result is finished on acceptance.
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (status.bypass) begin
						state_nx = ST_PASS;
					end else if (!status.skip) begin
						state_nx = ST_MUL;
					end
				end
			end
			ST_MUL: begin
				state_nx = ST_EMIT;
			end
			ST_EMIT: begin
				if (slot_free) begin
					state_nx = status.stop ? ST_IDLE : ST_MUL;
				end
			end
			ST_PASS: begin
				if (slot_free) begin
					state_nx = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	// State and output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.emit || cmd.pass) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

@@ rtl/lir_datapath.sv @@
// ----------------------------------------------------------------------------
// lir_datapath: arithmetic and state of the linear interpolation resampler
// Holds the configuration, the previous frame, the phase accumulator and the
// result counter, forms prev + phase * (cur - prev) per channel through a
// registered product stage and drives the output payload register.
// ----------------------------------------------------------------------------
module lir_datapath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [lir_pkg::CFG_IDX_BITS-1:0]    cfg_index,
	input  logic [lir_pkg::CFG_DATA_BITS-1:0]   cfg_data,
	input  lir_pkg::sample_t                    left_sample,
	input  lir_pkg::sample_t                    right_sample,
	input  logic                                block_last,
	input  lir_pkg::cmd_t                       cmd,
	output lir_pkg::status_t                    status,
	output lir_pkg::sample_t                    left_out,
	output lir_pkg::sample_t                    right_out,
	output logic                                run_last,
	output logic                                block_end
);
	import lir_pkg::*;

	// Round the product toward zero, add the held sample and saturate.
	function automatic sample_t lerp_finish(input sample_t held,
	                                        input logic signed [PROD_BITS-1:0] prod);
		logic signed [PROD_BITS-1:0]   adj;
		logic signed [PROD_BITS-1:0]   shifted;
		logic signed [SAMPLE_BITS+1:0] sum;
		logic signed [SAMPLE_BITS+1:0] maxv;
		logic signed [SAMPLE_BITS+1:0] minv;
		adj     = prod[PROD_BITS-1] ? (prod + $signed(ROUND_BIAS)) : prod;
		shifted = adj >>> PHASE_FRAC_BITS;
		sum     = $signed({{2{held[SAMPLE_BITS-1]}}, held}) + shifted[SAMPLE_BITS+1:0];
		maxv    = $signed({3'b000, {(SAMPLE_BITS-1){1'b1}}});
		minv    = $signed({3'b111, {(SAMPLE_BITS-1){1'b0}}});
		if (sum > maxv) begin
			lerp_finish = maxv[SAMPLE_BITS-1:0];
		end else if (sum < minv) begin
			lerp_finish = minv[SAMPLE_BITS-1:0];
		end else begin
			lerp_finish = sum[SAMPLE_BITS-1:0];
		end
	endfunction

	// Configuration registers.
	logic   resample_enable_q;
	phase_t step_ratio_q;
	logic   stereo_mode_q;

	// Frame history and phase.
	sample_t             held_left_q;
	sample_t             held_right_q;
	logic                have_history_q;
	phase_t              phase_acc_q;
	logic [CNT_BITS-1:0] cnt_q;

	// Captured frame.
	sample_t cur_left_q;
	sample_t cur_right_q;
	logic    cur_last_q;

	// Product stage.
	logic signed [PROD_BITS-1:0] prod_left_s1;
	logic signed [PROD_BITS-1:0] prod_right_s1;

	// Output payload.
	sample_t left_out_q;
	sample_t right_out_q;
	logic    run_last_q;
	logic    block_end_q;

	logic                          stereo;
	phase_t                        step_eff;
	phase_t                        phase_nx;
	logic                          stop;
	logic                          skip;
	logic signed [SAMPLE_BITS:0]   diff_left;
	logic signed [SAMPLE_BITS:0]   diff_right;
	logic signed [PHASE_FRAC_BITS+1:0] phase_mul;

	assign stereo = stereo_mode_q && (MAX_CHANNELS > 1);

	// Clamp the step into its usable range.
	always_comb begin
		if (step_ratio_q < STEP_MIN) begin
			step_eff = STEP_MIN;
		end else if (step_ratio_q > STEP_MAX) begin
			step_eff = STEP_MAX;
		end else begin
			step_eff = step_ratio_q;
		end
	end

	// Phase advance and end-of-frame decision.
	assign phase_nx = phase_acc_q + step_eff;
	assign stop     = (phase_nx > PH_ONE) || (cnt_q == CNT_BITS'(MAX_UPSAMPLE - 1));

	// With history in place and the phase past 1.0 the next frame gives nothing.
	assign skip = resample_enable_q && have_history_q && (phase_acc_q > PH_ONE);

	assign status.bypass = !resample_enable_q;
	assign status.skip   = skip;
	assign status.stop   = stop;

	// Differences and the phase operand; the phase is at most 1.0 here.
	assign diff_left  = $signed({cur_left_q[SAMPLE_BITS-1], cur_left_q})
	                  - $signed({held_left_q[SAMPLE_BITS-1], held_left_q});
	assign diff_right = $signed({cur_right_q[SAMPLE_BITS-1], cur_right_q})
	                  - $signed({held_right_q[SAMPLE_BITS-1], held_right_q});
	assign phase_mul  = $signed({1'b0, phase_acc_q[PHASE_FRAC_BITS:0]});

	// Configuration writes; unknown indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			resample_enable_q <= 1'b0;
			step_ratio_q      <= PH_ONE;
			stereo_mode_q     <= 1'b1;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_RESAMPLE_ENABLE: resample_enable_q <= cfg_data[0];
				REG_STEP_RATIO:      step_ratio_q      <= cfg_data;
				REG_STEREO_MODE:     stereo_mode_q     <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// History, phase and counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_left_q    <= '0;
			held_right_q   <= '0;
			have_history_q <= 1'b0;
			phase_acc_q    <= PH_ONE;
			cnt_q          <= '0;
		end else begin
			if (cmd.accept) begin
				cnt_q <= '0;
				if (resample_enable_q && !have_history_q) begin
					held_left_q <= left_sample;
					if (stereo) begin
						held_right_q <= right_sample;
					end
					phase_acc_q    <= PH_ONE;
					have_history_q <= 1'b1;
				end else if (skip) begin
					// No result: step the phase back by one and keep the frame.
					held_left_q <= left_sample;
					if (stereo) begin
						held_right_q <= right_sample;
					end
					phase_acc_q <= phase_acc_q - PH_ONE;
				end
			end
			if (cmd.emit) begin
				cnt_q <= cnt_q + CNT_BITS'(1);
				if (!stop) begin
					phase_acc_q <= phase_nx;
				end else if (phase_nx > PH_ONE) begin
					phase_acc_q <= phase_nx - PH_ONE;
				end else begin
					phase_acc_q <= PHASE_BITS'(1);
				end
			end
			if ((cmd.emit && stop) || cmd.pass) begin
				held_left_q <= cur_left_q;
				if (stereo) begin
					held_right_q <= cur_right_q;
				end
				have_history_q <= 1'b1;
			end
		end
	end

	// Frame capture.
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			cur_left_q  <= left_sample;
			cur_right_q <= right_sample;
			cur_last_q  <= block_last;
		end
	end

	// Interpolation products.
	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			prod_left_s1  <= PROD_BITS'(diff_left * phase_mul);
			prod_right_s1 <= PROD_BITS'(diff_right * phase_mul);
		end
	end

	// Output payload register.
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			left_out_q  <= lerp_finish(held_left_q, prod_left_s1);
			right_out_q <= stereo ? lerp_finish(held_right_q, prod_right_s1) : '0;
			run_last_q  <= stop;
			block_end_q <= stop && cur_last_q;
		end else if (cmd.pass) begin
			left_out_q  <= cur_left_q;
			right_out_q <= stereo ? cur_right_q : '0;
			run_last_q  <= 1'b1;
			block_end_q <= cur_last_q;
		end
	end

	assign left_out  = left_out_q;
	assign right_out = right_out_q;
	assign run_last  = run_last_q;
	assign block_end = block_end_q;

endmodule

@@ rtl/linear_interp_resampler.sv @@
// ----------------------------------------------------------------------------
// linear_interp_resampler: linear interpolation sample rate converter
// Takes one mono or stereo frame per input beat and emits the interpolated
// output samples that fall between the previous frame and this one.
//
// Usage:
//   Input channel: in_valid/in_ready with left_sample, right_sample and
//   block_last. One frame is taken at a time; in_ready is high whenever no
//   frame is in progress.
//   Output channel: out_valid/out_ready with left_out, right_out, run_last
//   and block_end. run_last marks the final beat caused by a frame.
//   Configuration: cfg_wr_en, cfg_index and cfg_data write resample_enable,
//   step_ratio and stereo_mode; write only while the block is idle.
//   Sequence: each interpolated result first has its products formed in the
//   shared multiplier pair, then is rounded, saturated and loaded into the
//   output register. A frame yields 0 to 16 results; after acceptance it
//   steps through the multiply and emit states once per result. A bypassed
//   frame gives one beat, loaded from the pass state.
//   Reset: clears the history, sets the phase to 1.0 and the registers to
//   their defaults; no clearing pass is needed.
//   Stall: when the receiver holds out_ready low the sequencer waits with
//   the next result; a new frame is taken while the final beat still waits.
// ----------------------------------------------------------------------------
module linear_interp_resampler (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [lir_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [lir_pkg::CFG_DATA_BITS-1:0] cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  lir_pkg::sample_t                  left_sample,
	input  lir_pkg::sample_t                  right_sample,
	input  logic                              block_last,
	output logic                              out_valid,
	input  logic                              out_ready,
	output lir_pkg::sample_t                  left_out,
	output lir_pkg::sample_t                  right_out,
	output logic                              run_last,
	output logic                              block_end
);
	import lir_pkg::*;

	cmd_t    cmd;
	status_t status;

	// Sequencer.
	lir_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	// Arithmetic, history and output payload.
	lir_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.left_sample  (left_sample),
		.right_sample (right_sample),
		.block_last   (block_last),
		.cmd          (cmd),
		.status       (status),
		.left_out     (left_out),
		.right_out    (right_out),
		.run_last     (run_last),
		.block_end    (block_end)
	);

endmodule
